>>> hdl/circular_linked_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Circular linked list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LINKED_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_LINKED_LIST_ENGINE_DEFINES_SVH

// Property holds at every edge out of reset.
`define CLL_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Property holds in the cycle after the condition.
`define CLL_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> hdl/cll_pkg.sv
// ----------------------------------------------------------------------------
// Circular linked list engine package
// Sizes, action and status codes, and the slot memory request and response
// words.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_HEAD,
    ACT_INS_TAIL,
    ACT_INS_AFTER,
    ACT_DEL_HEAD,
    ACT_DEL_TAIL,
    ACT_DEL_KEY,
    ACT_DUMP,
    ACT_UNUSED
  } action_t;

  localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_NOKEY = STATUS_W'(3);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    slot_t rd_addr;
    slot_t wr_addr;
    logic  wr_item_en;
    logic  wr_link_en;
    data_t wr_item;
    slot_t wr_link;
  } mem_req_t;

  typedef struct packed {
    data_t item;
    slot_t link;
  } mem_rsp_t;

endpackage

>>> hdl/cll_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot memory
// Item and link arrays, one write address and one registered read per cycle.
// ----------------------------------------------------------------------------
module cll_slot_mem (
  input  logic              clk,
  input  cll_pkg::mem_req_t req,
  output cll_pkg::mem_rsp_t rsp
);
  import cll_pkg::*;

  data_t items [CAPACITY];
  slot_t links [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_item_en) begin
      items[req.wr_addr] <= req.wr_item;
    end
    if (req.wr_link_en) begin
      links[req.wr_addr] <= req.wr_link;
    end
    rsp.item <= items[req.rd_addr];
    rsp.link <= links[req.rd_addr];
  end

endmodule

>>> hdl/cll_ctrl.sv
// ----------------------------------------------------------------------------
// List sequencer
// Walks the slot memory one link per cycle (a dump pauses while a result word
// waits), keeps the bitmap, tail and count, and holds the result word register.
// ----------------------------------------------------------------------------
`include "circular_linked_list_engine_defines.svh"

module cll_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  logic        [cll_pkg::ACTION_W-1:0] action,
  input  logic signed [cll_pkg::DATA_W-1:0]   key,
  input  logic signed [cll_pkg::DATA_W-1:0]   value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic        [cll_pkg::STATUS_W-1:0] status,
  output logic signed [cll_pkg::DATA_W-1:0]   item_out,
  output logic        [cll_pkg::ENTRY_W-1:0]  entry_count,
  output logic                               last_of_run,
  output cll_pkg::mem_req_t                  mem_req,
  input  cll_pkg::mem_rsp_t                  mem_rsp
);
  import cll_pkg::*;

  localparam int MAX_OUT  = 16;
  localparam int DUMP_LIM = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_DUMP = CNT_W'(DUMP_LIM);

  typedef logic [CAPACITY-1:0] slot_map_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SOLO,
    S_TAIL,
    S_LINK_TAIL,
    S_INS_SCAN,
    S_INS_LINK,
    S_DH_DATA,
    S_DK_HEAD,
    S_DK_SCAN,
    S_TP_SCAN,
    S_FREE,
    S_DUMP,
    S_RESP
  } state_t;

  state_t              state;
  logic [ACTION_W-1:0] act;
  data_t               key_r;
  data_t               val_r;
  slot_t               ptr;
  slot_t               prev;
  slot_t               head;
  slot_t               new_slot;
  slot_t               del_slot;
  logic [CNT_W-1:0]    step;
  logic [STATUS_W-1:0] st_r;
  data_t               item_r;
  slot_map_t           in_use;
  slot_t               tail;
  logic [CNT_W-1:0]    total;

  logic             key_hit;
  logic             link_hit;
  logic             can_load;
  logic             res_load;
  logic             mem_wr;
  logic             is_empty;
  logic             is_full;
  logic             multi;
  logic             dump_last;
  logic [CNT_W-1:0] dump_cnt;
  slot_t            free_slot;

  function automatic slot_t lowest_free(input slot_map_t used);
    slot_t idx;
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  function automatic slot_map_t slot_bit(input slot_t s);
    return slot_map_t'(1) << s;
  endfunction

  // one shared item comparator serves every key test
  assign key_hit   = (mem_rsp.item == key_r);
  assign link_hit  = (mem_rsp.link == tail);
  assign can_load  = !res_valid || res_ready;
  assign res_load  = ((state == S_DUMP) || (state == S_RESP)) && can_load;
  assign mem_wr    = mem_req.wr_item_en || mem_req.wr_link_en;
  assign is_empty  = (total == '0);
  assign is_full   = (total >= CNT_CAP);
  assign multi     = (total > CNT_ONE);
  assign dump_cnt  = (total > CNT_DUMP) ? CNT_DUMP : total;
  assign dump_last = ((step + CNT_ONE) == dump_cnt);
  assign free_slot = lowest_free(in_use);
  assign cmd_ready = (state == S_IDLE);

  // read address follows the link just read (the tail while idle, held while a dump waits)
  always_comb begin
    mem_req            = '0;
    mem_req.rd_addr    = mem_rsp.link;
    mem_req.wr_addr    = new_slot;
    mem_req.wr_item    = val_r;
    mem_req.wr_link    = mem_rsp.link;
    unique case (state)
      S_IDLE: begin
        mem_req.rd_addr = tail;
      end
      S_SOLO: begin
        mem_req.wr_item_en = 1'b1;
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_link    = new_slot;
      end
      S_TAIL: begin
        if (act == ACT_INS_HEAD || act == ACT_INS_TAIL ||
            (act == ACT_INS_AFTER && key_hit)) begin
          mem_req.wr_item_en = 1'b1;
          mem_req.wr_link_en = 1'b1;
        end
      end
      S_LINK_TAIL: begin
        mem_req.wr_addr    = tail;
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_link    = new_slot;
      end
      S_INS_SCAN: begin
        if (key_hit) begin
          mem_req.wr_item_en = 1'b1;
          mem_req.wr_link_en = 1'b1;
        end
      end
      S_INS_LINK: begin
        mem_req.wr_addr    = ptr;
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_link    = new_slot;
      end
      S_DH_DATA: begin
        if (multi) begin
          mem_req.wr_addr    = tail;
          mem_req.wr_link_en = 1'b1;
        end
      end
      S_DK_HEAD: begin
        if (key_hit && multi) begin
          mem_req.wr_addr    = tail;
          mem_req.wr_link_en = 1'b1;
        end
      end
      S_DK_SCAN: begin
        if (key_hit) begin
          mem_req.wr_addr    = prev;
          mem_req.wr_link_en = 1'b1;
        end
      end
      S_TP_SCAN: begin
        if (link_hit || step == CNT_CAP) begin
          mem_req.wr_addr    = ptr;
          mem_req.wr_link_en = 1'b1;
          mem_req.wr_link    = head;
        end
      end
      S_DUMP: begin
        if (!can_load) mem_req.rd_addr = ptr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      in_use    <= '0;
      tail      <= '0;
      total     <= '0;
    end else begin
      res_valid <= res_load || (res_valid && !res_ready);
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            act      <= action;
            key_r    <= key;
            val_r    <= value;
            new_slot <= free_slot;
            del_slot <= tail;
            item_r   <= '0;
            step     <= '0;
            unique case (action) inside
              ACT_INS_HEAD, ACT_INS_TAIL: begin
                if (is_full) begin
                  st_r  <= ST_FULL;
                  state <= S_RESP;
                end else if (is_empty) begin
                  st_r  <= ST_OK;
                  state <= S_SOLO;
                end else begin
                  st_r  <= ST_OK;
                  state <= S_TAIL;
                end
              end
              ACT_INS_AFTER: begin
                if (is_empty) begin
                  st_r  <= ST_EMPTY;
                  state <= S_RESP;
                end else if (is_full) begin
                  st_r  <= ST_FULL;
                  state <= S_RESP;
                end else begin
                  st_r  <= ST_OK;
                  state <= S_TAIL;
                end
              end
              ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_KEY, ACT_DUMP: begin
                if (is_empty) begin
                  st_r  <= ST_EMPTY;
                  state <= S_RESP;
                end else begin
                  st_r  <= ST_OK;
                  state <= S_TAIL;
                end
              end
              default: begin
                st_r  <= ST_OK;
                state <= S_RESP;
              end
            endcase
          end
        end
        S_SOLO: begin
          in_use <= in_use | slot_bit(new_slot);
          total  <= total + CNT_ONE;
          tail   <= new_slot;
          state  <= S_RESP;
        end
        S_TAIL: begin
          head <= mem_rsp.link;
          unique case (act) inside
            ACT_INS_HEAD, ACT_INS_TAIL: begin
              state <= S_LINK_TAIL;
            end
            ACT_INS_AFTER: begin
              if (key_hit) begin
                state <= S_LINK_TAIL;
              end else if (!multi) begin
                st_r  <= ST_NOKEY;
                state <= S_RESP;
              end else begin
                ptr   <= mem_rsp.link;
                step  <= total - CNT_ONE;
                state <= S_INS_SCAN;
              end
            end
            ACT_DEL_HEAD: begin
              state <= S_DH_DATA;
            end
            ACT_DEL_TAIL, ACT_DEL_KEY: begin
              if (act == ACT_DEL_TAIL || key_hit) begin
                item_r <= mem_rsp.item;
                if (multi) begin
                  ptr   <= mem_rsp.link;
                  step  <= '0;
                  state <= S_TP_SCAN;
                end else begin
                  state <= S_FREE;
                end
              end else begin
                state <= S_DK_HEAD;
              end
            end
            ACT_DUMP: begin
              ptr   <= mem_rsp.link;
              step  <= '0;
              state <= S_DUMP;
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_LINK_TAIL: begin
          in_use <= in_use | slot_bit(new_slot);
          total  <= total + CNT_ONE;
          if (act != ACT_INS_HEAD) tail <= new_slot;
          state  <= S_RESP;
        end
        S_INS_SCAN: begin
          if (key_hit) begin
            state <= S_INS_LINK;
          end else if (step == CNT_ONE) begin
            st_r  <= ST_NOKEY;
            state <= S_RESP;
          end else begin
            ptr  <= mem_rsp.link;
            step <= step - CNT_ONE;
          end
        end
        S_INS_LINK: begin
          in_use <= in_use | slot_bit(new_slot);
          total  <= total + CNT_ONE;
          state  <= S_RESP;
        end
        S_DH_DATA: begin
          item_r   <= mem_rsp.item;
          del_slot <= head;
          state    <= S_FREE;
        end
        S_DK_HEAD: begin
          if (key_hit) begin
            item_r   <= mem_rsp.item;
            del_slot <= head;
            state    <= S_FREE;
          end else if (link_hit) begin
            st_r  <= ST_NOKEY;
            state <= S_RESP;
          end else begin
            prev  <= head;
            ptr   <= mem_rsp.link;
            step  <= '0;
            state <= S_DK_SCAN;
          end
        end
        S_DK_SCAN: begin
          if (key_hit) begin
            item_r   <= mem_rsp.item;
            del_slot <= ptr;
            state    <= S_FREE;
          end else if (link_hit || step == CNT_LAST) begin
            st_r  <= ST_NOKEY;
            state <= S_RESP;
          end else begin
            prev <= ptr;
            ptr  <= mem_rsp.link;
            step <= step + CNT_ONE;
          end
        end
        S_TP_SCAN: begin
          // stop on the slot whose link names the tail, or at the step bound
          if (link_hit || step == CNT_CAP) begin
            tail  <= ptr;
            state <= S_FREE;
          end else begin
            ptr  <= mem_rsp.link;
            step <= step + CNT_ONE;
          end
        end
        S_FREE: begin
          in_use <= in_use & ~slot_bit(del_slot);
          total  <= total - CNT_ONE;
          if (total == CNT_ONE) tail <= '0;
          state  <= S_RESP;
        end
        S_DUMP: begin
          if (can_load) begin
            status      <= ST_OK;
            item_out    <= mem_rsp.item;
            entry_count <= ENTRY_W'(total);
            last_of_run <= dump_last;
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              ptr  <= mem_rsp.link;
              step <= step + CNT_ONE;
            end
          end
        end
        S_RESP: begin
          if (can_load) begin
            status      <= st_r;
            item_out    <= item_r;
            entry_count <= ENTRY_W'(total);
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CLL_ASSERT(a_count_bitmap, $countones(in_use) == int'(total), "count and bitmap disagree")
  `CLL_ASSERT(a_empty_tail, (total != '0) || (tail == '0), "empty list with nonzero tail")
  `CLL_ASSERT(a_idle_no_write, (state != S_IDLE) || !mem_wr, "slot write while idle")
  `CLL_ASSERT_NEXT(a_accept_busy, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")

endmodule

>>> hdl/circular_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Circular linked list engine
// Bounded circular singly linked list in slot memory, driven by list commands.
//
// Command channel (cmd_valid/cmd_ready) takes one word: action, key, value.
// Result channel (res_valid/res_ready) returns status, item_out, entry_count
// and last_of_run. Every action gives one word, except a dump of a nonempty
// list, which gives one word per item from head to tail, last one flagged.
// cmd_ready is high only while the sequencer is idle; one command is worked
// at a time. Cost per command is set by the link walk, one slot-memory read
// per cycle: inserts at head or tail need no walk, searches by key and delete
// tail walk the list, and a dump streams one word per cycle while the receiver
// takes them. A finished word waits in the output register while the next
// command is taken; a stalled receiver holds the sequencer only once it has
// its next word ready. Reset empties the list at once; slot memory needs no
// clearing pass.
// ----------------------------------------------------------------------------
module circular_linked_list_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  logic        [cll_pkg::ACTION_W-1:0] action,
  input  logic signed [cll_pkg::DATA_W-1:0]   key,
  input  logic signed [cll_pkg::DATA_W-1:0]   value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic        [cll_pkg::STATUS_W-1:0] status,
  output logic signed [cll_pkg::DATA_W-1:0]   item_out,
  output logic        [cll_pkg::ENTRY_W-1:0]  entry_count,
  output logic                               last_of_run
);
  import cll_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  cll_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .action      (action),
    .key         (key),
    .value       (value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .status      (status),
    .item_out    (item_out),
    .entry_count (entry_count),
    .last_of_run (last_of_run),
    .mem_req     (mem_req),
    .mem_rsp     (mem_rsp)
  );

  cll_slot_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule
